### hw/rtl/gffs_pkg.sv
// ----------------------------------------------------------------------------
// gffs_pkg
// Shared types, constants and neighbor tables of the grid flow-field solver.
// ----------------------------------------------------------------------------
package gffs_pkg;

   localparam int OP_BITS       = 2;
   localparam int XY_BITS       = 6;
   localparam int COST_BITS     = 8;
   localparam int CFG_BITS      = 7;
   localparam int OUT_DIST_BITS = 24;

   localparam logic [OP_BITS-1:0]   OP_LOAD  = 2'd0;
   localparam logic [OP_BITS-1:0]   OP_SOLVE = 2'd1;
   localparam logic [OP_BITS-1:0]   OP_READ  = 2'd2;
   localparam logic [COST_BITS-1:0] WALL     = 8'd255;

   localparam logic [CFG_BITS-1:0] GRID_RESET    = 7'd64;
   localparam logic                CSR_GRID_W    = 1'b0;
   localparam logic                CSR_GRID_H    = 1'b1;

   localparam logic [3:0] NB_CENTER = 4'd4;
   localparam logic [3:0] NB_COUNT  = 4'd9;
   localparam logic [1:0] STEP_NEG  = 2'b11;
   localparam logic [1:0] STEP_ZERO = 2'b00;
   localparam logic [1:0] STEP_POS  = 2'b01;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_SOLVE,
      CMD_READ,
      CMD_NOP
   } gffs_kind_type;

   typedef struct packed {
      gffs_kind_type          kind;
      logic [XY_BITS-1:0]     x;
      logic [XY_BITS-1:0]     y;
      logic [COST_BITS-1:0]   cost;
      logic                   target;
   } gffs_cmd_type;

   typedef struct packed {
      logic [1:0]                dir_x;
      logic [1:0]                dir_y;
      logic [OUT_DIST_BITS-1:0]  distance;
      logic                      solve_done;
   } gffs_rsp_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] grid_width;
      logic [CFG_BITS-1:0] grid_height;
   } gffs_cfg_type;

   typedef enum logic [3:0] {
      B_CLEAR,
      B_IDLE,
      B_READ_WAIT,
      B_INIT,
      B_SEED_RD,
      B_SEED_EVAL,
      B_POP,
      B_POP_WAIT,
      B_DC,
      B_NB_ISSUE,
      B_NB_EVAL,
      B_DIR_CELL,
      B_DIR_CWAIT,
      B_DIR_ISSUE,
      B_DIR_EVAL
   } gffs_state_type;

   // scan order: dy outer, dx inner, both -1..1
   function automatic logic [1:0] nb_dx(input logic [3:0] k);
      case (k) inside
         4'd0, 4'd3, 4'd6: nb_dx = STEP_NEG;
         4'd2, 4'd5, 4'd8: nb_dx = STEP_POS;
         default:          nb_dx = STEP_ZERO;
      endcase
   endfunction

   function automatic logic [1:0] nb_dy(input logic [3:0] k);
      case (k) inside
         4'd0, 4'd1, 4'd2: nb_dy = STEP_NEG;
         4'd6, 4'd7, 4'd8: nb_dy = STEP_POS;
         default:          nb_dy = STEP_ZERO;
      endcase
   endfunction

endpackage

### hw/rtl/gffs_ram.sv
// ----------------------------------------------------------------------------
// gffs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gffs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/gffs_front.sv
// ----------------------------------------------------------------------------
// gffs_front
// Accepts request beats, decodes the opcode and holds commands in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module gffs_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [gffs_pkg::OP_BITS-1:0]  req_opcode,
   input  logic [gffs_pkg::XY_BITS-1:0]  req_x,
   input  logic [gffs_pkg::XY_BITS-1:0]  req_y,
   input  logic [gffs_pkg::COST_BITS-1:0] req_cost,
   input  logic                          req_target,
   output logic                          cmd_valid,
   input  logic                          cmd_pop,
   output gffs_pkg::gffs_cmd_type        cmd
);
   import gffs_pkg::*;

   gffs_cmd_type q_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   gffs_cmd_type dec;
   logic         push;

   always_comb begin
      dec.x      = req_x;
      dec.y      = req_y;
      dec.cost   = req_cost;
      dec.target = req_target;
      unique case (req_opcode)
         OP_LOAD:  dec.kind = CMD_LOAD;
         OP_SOLVE: dec.kind = CMD_SOLVE;
         OP_READ:  dec.kind = CMD_READ;
         default:  dec.kind = CMD_NOP;
      endcase
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != 2'd0);
   assign cmd        = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

### hw/rtl/gffs_back.sv
// ----------------------------------------------------------------------------
// gffs_back
// Command engine: cell stores, relaxation queue, direction pass and the
// result register.
// ----------------------------------------------------------------------------
module gffs_back #(
   parameter int MAX_SIDE  = 64,
   parameter int DIST_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gffs_pkg::gffs_cfg_type cfg,
   input  logic                   cmd_valid,
   output logic                   cmd_pop,
   input  gffs_pkg::gffs_cmd_type cmd,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output gffs_pkg::gffs_rsp_type rsp
);
   import gffs_pkg::*;

   localparam int CELLS      = MAX_SIDE * MAX_SIDE;
   localparam int CELL_BITS  = $clog2(CELLS);
   localparam int COORD_BITS = $clog2(MAX_SIDE);
   localparam int SIDE_BITS  = $clog2(MAX_SIDE + 1);
   localparam int CB         = (SIDE_BITS > CFG_BITS) ? SIDE_BITS : CFG_BITS;
   localparam int QW         = 2 * COORD_BITS;
   localparam int WB         = (DIST_BITS > OUT_DIST_BITS) ? DIST_BITS : OUT_DIST_BITS;
   localparam logic [DIST_BITS-1:0] DIST_ONES = {DIST_BITS{1'b1}};
   localparam logic [OUT_DIST_BITS-1:0] OUT_ONES = {OUT_DIST_BITS{1'b1}};

   function automatic logic [CELL_BITS-1:0] cell_addr(input logic [COORD_BITS-1:0] x,
                                                      input logic [COORD_BITS-1:0] y);
      cell_addr = CELL_BITS'(CELL_BITS'(y) * CELL_BITS'(MAX_SIDE) + CELL_BITS'(x));
   endfunction

   function automatic logic [SIDE_BITS-1:0] used_side(input logic [CFG_BITS-1:0] v);
      if (v == '0) begin
         used_side = SIDE_BITS'(1);
      end else if (CB'(v) > CB'(MAX_SIDE)) begin
         used_side = SIDE_BITS'(MAX_SIDE);
      end else begin
         used_side = SIDE_BITS'(v);
      end
   endfunction

   gffs_state_type state_ff, state_in;
   logic [CELL_BITS-1:0]  clr_ff, clr_in;
   logic [COORD_BITS-1:0] sx_ff, sx_in, sy_ff, sy_in, cx_ff, cx_in, cy_ff, cy_in;
   logic [COORD_BITS-1:0] nx_ff, nx_in, ny_ff, ny_in;
   logic [3:0]            k_ff, k_in;
   logic [DIST_BITS-1:0]  dc_ff, dc_in, best_ff, best_in;
   logic [3:0]            dacc_ff, dacc_in;
   logic [CELL_BITS-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [CELL_BITS:0]    count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   gffs_rsp_type          rsp_ff, rsp_in;

   // RAM ports
   logic                  cost_we, tgt_we, dist_we, dir_we, flag_we, q_we;
   logic [CELL_BITS-1:0]  cost_wa, tgt_wa, dist_wa, dir_wa, flag_wa, q_wa;
   logic [CELL_BITS-1:0]  cost_ra, tgt_ra, dist_ra, dir_ra, flag_ra, q_ra;
   logic [COST_BITS-1:0]  cost_wd, cost_rd;
   logic                  tgt_wd, tgt_rd, flag_wd, flag_rd;
   logic [DIST_BITS-1:0]  dist_wd, dist_rd;
   logic [3:0]            dir_wd, dir_rd;
   logic [QW-1:0]         q_wd, q_rd;

   // shared combinational terms
   logic [SIDE_BITS-1:0]  wu, hu;
   logic [COORD_BITS-1:0] cmd_cx, cmd_cy;
   logic                  load_ok, read_ok, clr_last, scan_x_last, scan_y_last;
   logic [1:0]            sdx, sdy;
   logic [SIDE_BITS-1:0]  nxw, nyw;
   logic                  nb_ok;
   logic [CELL_BITS-1:0]  n_addr, c_addr, s_addr;
   logic [DIST_BITS:0]    sum_w;
   logic [DIST_BITS-1:0]  sum_sat;
   logic [WB-1:0]         dist_wide;

   assign wu          = used_side(cfg.grid_width);
   assign hu          = used_side(cfg.grid_height);
   assign cmd_cx      = COORD_BITS'(cmd.x);
   assign cmd_cy      = COORD_BITS'(cmd.y);
   assign load_ok     = (CB'(cmd.x) < CB'(MAX_SIDE)) && (CB'(cmd.y) < CB'(MAX_SIDE));
   assign read_ok     = (CB'(cmd.x) < CB'(wu)) && (CB'(cmd.y) < CB'(hu));
   assign clr_last    = (clr_ff == CELL_BITS'(CELLS - 1));
   assign scan_x_last = (SIDE_BITS'(sx_ff) + SIDE_BITS'(1) == wu);
   assign scan_y_last = (SIDE_BITS'(sy_ff) + SIDE_BITS'(1) == hu);
   assign s_addr      = cell_addr(sx_ff, sy_ff);
   assign c_addr      = cell_addr(cx_ff, cy_ff);

   always_comb begin
      sdx = nb_dx(k_ff);
      sdy = nb_dy(k_ff);
      case (sdx)
         STEP_NEG: nxw = SIDE_BITS'(cx_ff) - SIDE_BITS'(1);
         STEP_POS: nxw = SIDE_BITS'(cx_ff) + SIDE_BITS'(1);
         default:  nxw = SIDE_BITS'(cx_ff);
      endcase
      case (sdy)
         STEP_NEG: nyw = SIDE_BITS'(cy_ff) - SIDE_BITS'(1);
         STEP_POS: nyw = SIDE_BITS'(cy_ff) + SIDE_BITS'(1);
         default:  nyw = SIDE_BITS'(cy_ff);
      endcase
      nb_ok = (nxw < wu) && (nyw < hu)
              && !(sdx == STEP_NEG && cx_ff == '0)
              && !(sdy == STEP_NEG && cy_ff == '0);
      n_addr = cell_addr(COORD_BITS'(nxw), COORD_BITS'(nyw));
   end

   assign sum_w     = {1'b0, dc_ff} + (DIST_BITS + 1)'(cost_rd);
   assign sum_sat   = sum_w[DIST_BITS] ? DIST_ONES : sum_w[DIST_BITS-1:0];
   assign dist_wide = WB'(dist_rd);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_CLEAR:     if (clr_last) state_in = B_IDLE;
         B_IDLE: begin
            if (cmd_valid && !rsp_valid_ff) begin
               if (cmd.kind == CMD_SOLVE) state_in = B_INIT;
               else if (cmd.kind == CMD_READ && read_ok) state_in = B_READ_WAIT;
            end
         end
         B_READ_WAIT: state_in = B_IDLE;
         B_INIT:      if (clr_last) state_in = B_SEED_RD;
         B_SEED_RD:   state_in = B_SEED_EVAL;
         B_SEED_EVAL: state_in = (scan_x_last && scan_y_last) ? B_POP : B_SEED_RD;
         B_POP:       state_in = (count_ff == '0) ? B_DIR_CELL : B_POP_WAIT;
         B_POP_WAIT:  state_in = B_DC;
         B_DC:        state_in = B_NB_ISSUE;
         B_NB_ISSUE: begin
            if (k_ff == NB_COUNT) state_in = B_POP;
            else if (nb_ok) state_in = B_NB_EVAL;
         end
         B_NB_EVAL:   state_in = B_NB_ISSUE;
         B_DIR_CELL:  state_in = B_DIR_CWAIT;
         B_DIR_CWAIT: state_in = B_DIR_ISSUE;
         B_DIR_ISSUE: begin
            if (k_ff == NB_COUNT) begin
               state_in = (scan_x_last && scan_y_last) ? B_IDLE : B_DIR_CELL;
            end else if (nb_ok) begin
               state_in = B_DIR_EVAL;
            end
         end
         B_DIR_EVAL:  state_in = B_DIR_ISSUE;
         default:     state_in = B_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      clr_in = clr_ff;  sx_in = sx_ff;  sy_in = sy_ff;  cx_in = cx_ff;  cy_in = cy_ff;
      nx_in = nx_ff;  ny_in = ny_ff;  k_in = k_ff;  dc_in = dc_ff;  best_in = best_ff;
      dacc_in = dacc_ff;  head_in = head_ff;  tail_in = tail_ff;  count_in = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      cmd_pop = 1'b0;
      cost_we = 1'b0;  cost_wa = cell_addr(cmd_cx, cmd_cy);  cost_wd = cmd.cost;
      tgt_we  = 1'b0;  tgt_wa  = cell_addr(cmd_cx, cmd_cy);  tgt_wd  = cmd.target;
      dist_we = 1'b0;  dist_wa = clr_ff;  dist_wd = DIST_ONES;
      dir_we  = 1'b0;  dir_wa  = clr_ff;  dir_wd  = '0;
      flag_we = 1'b0;  flag_wa = clr_ff;  flag_wd = 1'b0;
      q_we    = 1'b0;  q_wa    = tail_ff;  q_wd   = {cy_ff, cx_ff};
      cost_ra = n_addr;  flag_ra = n_addr;  dist_ra = n_addr;
      dir_ra  = cell_addr(cmd_cx, cmd_cy);  tgt_ra  = s_addr;  q_ra = head_ff;

      unique case (state_ff)
         B_CLEAR: begin
            tgt_we = 1'b1;  tgt_wa = clr_ff;  tgt_wd = 1'b0;
            dist_we = 1'b1;  dir_we = 1'b1;  flag_we = 1'b1;
            clr_in = clr_ff + CELL_BITS'(1);
         end
         B_IDLE: begin
            clr_in = '0;
            dist_ra = cell_addr(cmd_cx, cmd_cy);
            if (cmd_valid && !rsp_valid_ff) begin
               cmd_pop = 1'b1;
               rsp_in = '0;
               case (cmd.kind)
                  CMD_LOAD: begin
                     cost_we = load_ok;
                     tgt_we  = load_ok;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_READ: begin
                     if (!read_ok) begin
                        rsp_in.distance = OUT_ONES;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  CMD_NOP:  rsp_valid_in = 1'b1;
                  default:  ;
               endcase
            end
         end
         B_READ_WAIT: begin
            rsp_in.dir_x = dir_rd[3:2];
            rsp_in.dir_y = dir_rd[1:0];
            rsp_in.distance = (dist_wide > WB'(OUT_ONES)) ? OUT_ONES
                                                         : OUT_DIST_BITS'(dist_wide);
            rsp_in.solve_done = 1'b0;
            rsp_valid_in = 1'b1;
         end
         B_INIT: begin
            dist_we = 1'b1;  dir_we = 1'b1;  flag_we = 1'b1;
            clr_in = clr_ff + CELL_BITS'(1);
            sx_in = '0;  sy_in = '0;
            head_in = '0;  tail_in = '0;  count_in = '0;
         end
         B_SEED_RD: ;
         B_SEED_EVAL: begin
            if (tgt_rd) begin
               dist_we = 1'b1;  dist_wa = s_addr;  dist_wd = '0;
               flag_we = 1'b1;  flag_wa = s_addr;  flag_wd = 1'b1;
               q_we = 1'b1;  q_wd = {sy_ff, sx_ff};
               tail_in = (tail_ff == CELL_BITS'(CELLS - 1)) ? '0 : tail_ff + CELL_BITS'(1);
               count_in = count_ff + (CELL_BITS + 1)'(1);
            end
            if (scan_x_last) begin
               sx_in = '0;
               sy_in = scan_y_last ? '0 : sy_ff + COORD_BITS'(1);
            end else begin
               sx_in = sx_ff + COORD_BITS'(1);
            end
         end
         B_POP: begin
            if (count_ff != '0) begin
               head_in = (head_ff == CELL_BITS'(CELLS - 1)) ? '0 : head_ff + CELL_BITS'(1);
               count_in = count_ff - (CELL_BITS + 1)'(1);
            end
         end
         B_POP_WAIT: begin
            cx_in = q_rd[COORD_BITS-1:0];
            cy_in = q_rd[QW-1:COORD_BITS];
            flag_we = 1'b1;
            flag_wa = cell_addr(q_rd[COORD_BITS-1:0], q_rd[QW-1:COORD_BITS]);
            flag_wd = 1'b0;
            dist_ra = cell_addr(q_rd[COORD_BITS-1:0], q_rd[QW-1:COORD_BITS]);
         end
         B_DC: begin
            dc_in = dist_rd;
            k_in = '0;
         end
         B_NB_ISSUE: begin
            nx_in = COORD_BITS'(nxw);
            ny_in = COORD_BITS'(nyw);
            if (k_ff != NB_COUNT && !nb_ok) k_in = k_ff + 4'd1;
         end
         B_NB_EVAL: begin
            // relax this neighbor; queue it unless already waiting
            if (cost_rd != WALL && sum_sat < dist_rd) begin
               dist_we = 1'b1;  dist_wa = cell_addr(nx_ff, ny_ff);  dist_wd = sum_sat;
               if (!flag_rd) begin
                  flag_we = 1'b1;  flag_wa = cell_addr(nx_ff, ny_ff);  flag_wd = 1'b1;
                  q_we = 1'b1;  q_wd = {ny_ff, nx_ff};
                  tail_in = (tail_ff == CELL_BITS'(CELLS - 1)) ? '0
                                                                : tail_ff + CELL_BITS'(1);
                  count_in = count_ff + (CELL_BITS + 1)'(1);
               end
            end
            k_in = k_ff + 4'd1;
         end
         B_DIR_CELL: begin
            cx_in = sx_ff;
            cy_in = sy_ff;
            dist_ra = s_addr;
         end
         B_DIR_CWAIT: begin
            best_in = dist_rd;
            dacc_in = '0;
            k_in = '0;
         end
         B_DIR_ISSUE: begin
            if (k_ff == NB_COUNT) begin
               dir_we = 1'b1;  dir_wa = c_addr;  dir_wd = dacc_ff;
               if (scan_x_last) begin
                  sx_in = '0;
                  sy_in = sy_ff + COORD_BITS'(1);
                  if (scan_y_last) begin
                     rsp_in = '0;
                     rsp_in.solve_done = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
               end else begin
                  sx_in = sx_ff + COORD_BITS'(1);
               end
            end else if (!nb_ok) begin
               k_in = k_ff + 4'd1;
            end
         end
         B_DIR_EVAL: begin
            if (dist_rd <= best_ff) begin
               best_in = dist_rd;
               if (k_ff != NB_CENTER) dacc_in = {nb_dx(k_ff), nb_dy(k_ff)};
            end
            k_in = k_ff + 4'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sx_ff   <= sx_in;   sy_ff <= sy_in;   cx_ff <= cx_in;   cy_ff <= cy_in;
      nx_ff   <= nx_in;   ny_ff <= ny_in;   k_ff  <= k_in;
      dc_ff   <= dc_in;   best_ff <= best_in;  dacc_ff <= dacc_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   gffs_ram #(.WIDTH(COST_BITS), .DEPTH(CELLS)) u_cost (
      .clock(clock), .wr_en(cost_we), .wr_addr(cost_wa), .wr_data(cost_wd),
      .rd_addr(cost_ra), .rd_data(cost_rd));
   gffs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_target (
      .clock(clock), .wr_en(tgt_we), .wr_addr(tgt_wa), .wr_data(tgt_wd),
      .rd_addr(tgt_ra), .rd_data(tgt_rd));
   gffs_ram #(.WIDTH(DIST_BITS), .DEPTH(CELLS)) u_dist (
      .clock(clock), .wr_en(dist_we), .wr_addr(dist_wa), .wr_data(dist_wd),
      .rd_addr(dist_ra), .rd_data(dist_rd));
   gffs_ram #(.WIDTH(4), .DEPTH(CELLS)) u_dir (
      .clock(clock), .wr_en(dir_we), .wr_addr(dir_wa), .wr_data(dir_wd),
      .rd_addr(dir_ra), .rd_data(dir_rd));
   gffs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_flag (
      .clock(clock), .wr_en(flag_we), .wr_addr(flag_wa), .wr_data(flag_wd),
      .rd_addr(flag_ra), .rd_data(flag_rd));
   gffs_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_addr(q_ra), .rd_data(q_rd));

endmodule

### hw/rtl/grid_flow_field_solver.sv
// ----------------------------------------------------------------------------
// grid_flow_field_solver
// 8-neighbor flow-field solver over a grid of cell costs and targets.
// ----------------------------------------------------------------------------
// After reset a clearing pass over all MAX_SIDE*MAX_SIDE cells (4096 by
// default) runs before the first command is carried out. The command queue
// takes up to two beats in the meantime. A load or an unused opcode is
// answered from the idle state; a read in the grid waits on the registered
// store reads. A solve resets the distance, direction and queued-flag stores
// over all cells, then scans each in-use cell to seed targets, then pops the
// queue until empty, relaxing each popped cell's in-grid neighbors in turn.
// The direction pass visits each in-use cell and its in-grid neighbors the
// same way. Each cell store has a single read port, so neighbors are read
// one at a time. Commands wait in a two-entry queue, so up to two request
// beats are taken while a result beat waits to be taken.
module grid_flow_field_solver #(
   parameter int MAX_SIDE  = 64,
   parameter int DIST_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[1:0], cell_x[7:2], cell_y[13:8], cell_cost[21:14], is_target[22]
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // dir_x[1:0], dir_y[3:2], distance[27:4], solve_done[28]
   output logic [31:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata
);
   import gffs_pkg::*;

   gffs_cfg_type cfg_ff, cfg_in;
   gffs_cmd_type cmd;
   gffs_rsp_type rsp;
   logic         cmd_valid, cmd_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GRID_W: cfg_in.grid_width  = csr_wdata;
            CSR_GRID_H: cfg_in.grid_height = csr_wdata;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width  <= GRID_RESET;
         cfg_ff.grid_height <= GRID_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gffs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tdata[1:0]),
      .req_x      (req_tdata[7:2]),
      .req_y      (req_tdata[13:8]),
      .req_cost   (req_tdata[21:14]),
      .req_target (req_tdata[22]),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd        (cmd)
   );

   gffs_back #(.MAX_SIDE(MAX_SIDE), .DIST_BITS(DIST_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {3'b000, rsp.solve_done, rsp.distance, rsp.dir_y, rsp.dir_x};

endmodule
